[sv/cbt_pkg.sv]
// Shared types and constants for the service circuit-breaker table.
package cbt_pkg;

  // Counter ceiling for refs, active and failure counts
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Register port
  localparam int unsigned CBT_ADDR_W = 4;

  localparam logic [15:0] MAX_CONC_RST  = 16'd32;
  localparam logic [15:0] MAX_FAIL_RST  = 16'd3;
  localparam logic [15:0] BREAK_SEC_RST = 16'd10;

  typedef enum logic [1:0] {
    REG_MAX_CONC  = 2'd0,
    REG_MAX_FAIL  = 2'd1,
    REG_BREAK_SEC = 2'd2
  } reg_idx_e;

  // Event codes
  typedef enum logic [2:0] {
    OP_ATTACH = 3'd0,
    OP_DETACH = 3'd1,
    OP_INVOKE = 3'd2,
    OP_FAILED = 3'd3,
    OP_FINISH = 3'd4
  } op_e;

  // Result codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NO_ENTRY  = 3'd1,
    STAT_TOO_MANY  = 3'd2,
    STAT_OPEN      = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_NOT_FOUND = 3'd5
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_WAIT = 2'd2,
    S_EXEC = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] service_key;
    logic [31:0] now_seconds;
  } cbt_req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] active_now;
    logic [15:0] failures_now;
  } cbt_res_t;

  typedef struct packed {
    logic [15:0] max_concurrent;
    logic [15:0] max_failures;
    logic [15:0] break_seconds;
  } cbt_cfg_t;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] refs;
    logic [15:0] active;
    logic [15:0] failures;
    logic [31:0] last_time;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic exec;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

[sv/cbt_regs.sv]
// Configuration registers behind the APB-style port.
module cbt_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbt_pkg::CBT_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output cbt_pkg::cbt_cfg_t              cfg_o
);
  import cbt_pkg::*;

  cbt_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MAX_CONC:  cfg_d.max_concurrent = pwdata[15:0];
        REG_MAX_FAIL:  cfg_d.max_failures   = pwdata[15:0];
        REG_BREAK_SEC: cfg_d.break_seconds  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_concurrent <= MAX_CONC_RST;
      cfg_q.max_failures   <= MAX_FAIL_RST;
      cfg_q.break_seconds  <= BREAK_SEC_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_MAX_CONC:  prdata = {16'd0, cfg_q.max_concurrent};
      REG_MAX_FAIL:  prdata = {16'd0, cfg_q.max_failures};
      REG_BREAK_SEC: prdata = {16'd0, cfg_q.break_seconds};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[sv/cbt_ctrl.sv]
// Sequencer: load, key scan, final compare, update and result.
module cbt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output cbt_pkg::dp_cmd_t cmd_o,
  input  cbt_pkg::dp_sts_t sts_i
);
  import cbt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_WAIT;
        end
      end
      // last read entry is compared here
      S_WAIT: state_d = S_EXEC;
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[sv/cbt_dp.sv]
// Datapath: entry memory, valid bits, key scan and per-event update.
module cbt_dp #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbt_pkg::dp_cmd_t  cmd_i,
  output cbt_pkg::dp_sts_t  sts_o,
  input  cbt_pkg::cbt_req_t req_i,
  input  cbt_pkg::cbt_cfg_t cfg_i,
  output cbt_pkg::cbt_res_t res_o,
  output logic              res_valid_o
);
  import cbt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  entry_t mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  cbt_req_t         req_q;
  logic [IDX_W-1:0] idx_q, rd_idx_q, hit_idx_q, free_idx_q;
  logic             rd_chk_q, hit_q, free_q;
  entry_t           rd_data_q, hit_data_q;
  cbt_res_t         res_q;
  logic             res_valid_q;

  entry_t           cur, nxt;
  cbt_res_t         res_d;
  logic             wr_en, vld_set, vld_clr, open_win;
  logic [IDX_W-1:0] wr_idx;
  logic [32:0]      win_end;
  logic [15:0]      refs_dec;
  logic             key_hit, slot_free;

  assign sts_o.scan_last = (idx_q == LAST_IDX);

  // Entry memory: one read port for the scan, one write port for the update
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem_q[idx_q];
    end
    if (cmd_i.exec && wr_en) begin
      mem_q[wr_idx] <= nxt;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.exec) begin
      if (vld_set) begin
        valid_q[wr_idx] <= 1'b1;
      end else if (vld_clr) begin
        valid_q[wr_idx] <= 1'b0;
      end
    end
  end

  assign key_hit   = rd_chk_q && valid_q[rd_idx_q] && (rd_data_q.key == req_q.service_key);
  assign slot_free = rd_chk_q && !valid_q[rd_idx_q];

  // Scan control and match flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_chk_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      rd_chk_q    <= cmd_i.scan_rd;
      res_valid_q <= cmd_i.exec;
      if (cmd_i.load) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          idx_q <= idx_q + 1'b1;
        end
        if (key_hit) begin
          hit_q <= 1'b1;
        end
        if (slot_free) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // Scan payload: request, read index, first hit, first free slot and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.scan_rd) begin
      rd_idx_q <= idx_q;
    end
    if (key_hit && !hit_q) begin
      hit_idx_q  <= rd_idx_q;
      hit_data_q <= rd_data_q;
    end
    if (slot_free && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  // Event update on the matched entry, or on the lowest free slot for a new key
  always_comb begin
    cur      = hit_data_q;
    nxt      = cur;
    res_d    = '{status: STAT_OK, active_now: 16'd0, failures_now: 16'd0};
    wr_en    = 1'b0;
    vld_set  = 1'b0;
    vld_clr  = 1'b0;
    wr_idx   = hit_idx_q;
    win_end  = {1'b0, cur.last_time} + {17'd0, cfg_i.break_seconds};
    open_win = ({1'b0, req_q.now_seconds} < win_end);
    refs_dec = (cur.refs != 16'd0) ? cur.refs - 16'd1 : 16'd0;
    unique case (req_q.op)
      OP_ATTACH: begin
        if (hit_q) begin
          nxt.refs           = (cur.refs == CNT_MAX) ? cur.refs : cur.refs + 16'd1;
          wr_en              = 1'b1;
          res_d.active_now   = cur.active;
          res_d.failures_now = cur.failures;
        end else if (free_q) begin
          // fresh entry in the lowest free slot
          wr_idx  = free_idx_q;
          nxt     = '{key: req_q.service_key, refs: 16'd1, active: 16'd0,
                      failures: 16'd0, last_time: 32'd0};
          wr_en   = 1'b1;
          vld_set = 1'b1;
        end else begin
          res_d.status = STAT_FULL;
        end
      end
      OP_DETACH: begin
        if (!hit_q) begin
          res_d.status = STAT_NOT_FOUND;
        end else if (refs_dec == 16'd0) begin
          vld_clr = 1'b1;
        end else begin
          nxt.refs           = refs_dec;
          wr_en              = 1'b1;
          res_d.active_now   = cur.active;
          res_d.failures_now = cur.failures;
        end
      end
      OP_INVOKE: begin
        if (!hit_q) begin
          res_d.status = STAT_NO_ENTRY;
        end else begin
          if (cur.active > cfg_i.max_concurrent) begin
            res_d.status = STAT_TOO_MANY;
          end else if (cur.failures > cfg_i.max_failures && open_win) begin
            res_d.status = STAT_OPEN;
          end else begin
            // granted: stale failures drop, call counted, time stamped
            if (cur.failures > cfg_i.max_failures) begin
              nxt.failures = 16'd0;
            end
            nxt.active    = (cur.active == CNT_MAX) ? cur.active : cur.active + 16'd1;
            nxt.last_time = req_q.now_seconds;
            wr_en         = 1'b1;
          end
          res_d.active_now   = nxt.active;
          res_d.failures_now = nxt.failures;
        end
      end
      OP_FAILED: begin
        if (!hit_q) begin
          res_d.status = STAT_NOT_FOUND;
        end else begin
          nxt.failures = (cur.failures == CNT_MAX) ? cur.failures : cur.failures + 16'd1;
          wr_en              = 1'b1;
          res_d.active_now   = nxt.active;
          res_d.failures_now = nxt.failures;
        end
      end
      OP_FINISH: begin
        if (!hit_q) begin
          res_d.status = STAT_NOT_FOUND;
        end else begin
          nxt.active         = (cur.active != 16'd0) ? cur.active - 16'd1 : 16'd0;
          wr_en              = 1'b1;
          res_d.active_now   = nxt.active;
          res_d.failures_now = nxt.failures;
        end
      end
      default: ;
    endcase
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

[sv/service_circuit_breaker_table_top.sv]
// Top level of the service circuit-breaker table.
// An event is taken when start is high and busy is low; its single result
// beat appears on res_o with res_valid_o high for exactly one cycle, and the
// receiver cannot stall it. Between acceptance and the next possible
// acceptance the key lookup walks the entry memory one entry per cycle
// through its single read port, then the wait state finishes the last
// compare and the exec state applies the update. The result beat
// comes out in the cycle where busy has dropped again, so the next event may
// be taken alongside it. There is no clearing pass after reset: entry valid
// bits are flip-flops cleared by reset. Configuration writes go through the
// APB-style port at any time and must be made only while the block is idle.
module service_circuit_breaker_table_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  cbt_pkg::cbt_req_t              req_i,
  output cbt_pkg::cbt_res_t              res_o,
  output logic                           res_valid_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbt_pkg::CBT_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import cbt_pkg::*;

  cbt_cfg_t cfg;
  dp_cmd_t  cmd;
  dp_sts_t  sts;

  cbt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  cbt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  // An accepted event keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted event");

  // A result beat only comes out once the block has gone idle
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result beat while busy");

  // Leaving busy always delivers the result
  a_done_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("busy dropped without a result beat");

  // One result beat per event
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result beat repeated");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the service circuit-breaker table: event beats in, result beats checked.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cbt_pkg::*;

  localparam int SLOTS          = 16;
  localparam int KEY_POOL       = 28;
  localparam int RAND_PER_PHASE = 100;
  localparam int RUN_LIMIT      = 200000;

  // Event codes the block does not define
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic                  clk_i;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  cbt_req_t              req_i   = '0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CBT_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic                  busy;
  cbt_res_t              res_o;
  logic                  res_valid_o;
  logic [31:0]           prdata;
  logic                  pready;

  service_circuit_breaker_table_top #(
    .TABLE_ENTRIES(SLOTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Breaker table mirror plus the queue of results still owed by the block
  class breaker_scoreboard;
    logic        slot_valid [SLOTS];
    logic [31:0] slot_key   [SLOTS];
    logic [15:0] slot_refs  [SLOTS];
    logic [15:0] slot_active[SLOTS];
    logic [15:0] slot_fails [SLOTS];
    logic [31:0] slot_stamp [SLOTS];
    logic [15:0] lim_active;
    logic [15:0] lim_fails;
    logic [15:0] lim_break;
    cbt_res_t    owed[$];
    int unsigned fail_count;

    function new();
      lim_active = MAX_CONC_RST;
      lim_fails  = MAX_FAIL_RST;
      lim_break  = BREAK_SEC_RST;
      fail_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i]  = 1'b0;
        slot_refs[i]   = '0;
        slot_active[i] = '0;
        slot_fails[i]  = '0;
        slot_stamp[i]  = '0;
      end
    endfunction

    function void set_limit(reg_idx_e idx, logic [15:0] val);
      case (idx)
        REG_MAX_CONC:  lim_active = val;
        REG_MAX_FAIL:  lim_fails  = val;
        REG_BREAK_SEC: lim_break  = val;
        default: ;
      endcase
    endfunction

    // Apply one event to the mirror and return the result beat it should give
    function cbt_res_t predict_event(cbt_req_t req);
      int          hit;
      int          spare;
      bit          show;
      cbt_res_t    r;
      logic [32:0] shut_until;
      hit  = -1;
      spare = -1;
      show = 1'b0;
      r.status       = STAT_OK;
      r.active_now   = '0;
      r.failures_now = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_key[i] == req.service_key && hit < 0) hit = i;
        if (!slot_valid[i] && spare < 0) spare = i;
      end
      case (req.op)
        OP_ATTACH: begin
          // lowest free slot takes a new key
          if (hit < 0 && spare >= 0) begin
            hit = spare;
            slot_valid[hit]  = 1'b1;
            slot_key[hit]    = req.service_key;
            slot_refs[hit]   = '0;
            slot_active[hit] = '0;
            slot_fails[hit]  = '0;
            slot_stamp[hit]  = '0;
          end
          if (hit < 0) begin
            r.status = STAT_FULL;
          end else begin
            if (slot_refs[hit] != CNT_MAX) slot_refs[hit]++;
            show = 1'b1;
          end
        end
        OP_DETACH: begin
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            if (slot_refs[hit] != 0) slot_refs[hit]--;
            if (slot_refs[hit] == 0) slot_valid[hit] = 1'b0;
            else show = 1'b1;
          end
        end
        OP_INVOKE: begin
          if (hit < 0) begin
            r.status = STAT_NO_ENTRY;
          end else begin
            // open window is compared one bit wider so it never wraps
            shut_until = {1'b0, slot_stamp[hit]} + {17'd0, lim_break};
            if (slot_active[hit] > lim_active) begin
              r.status = STAT_TOO_MANY;
            end else if (slot_fails[hit] > lim_fails &&
                         {1'b0, req.now_seconds} < shut_until) begin
              r.status = STAT_OPEN;
            end else begin
              if (slot_fails[hit] > lim_fails) slot_fails[hit] = '0;
              if (slot_active[hit] != CNT_MAX) slot_active[hit]++;
              slot_stamp[hit] = req.now_seconds;
            end
            show = 1'b1;
          end
        end
        OP_FAILED: begin
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            if (slot_fails[hit] != CNT_MAX) slot_fails[hit]++;
            show = 1'b1;
          end
        end
        OP_FINISH: begin
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            if (slot_active[hit] != 0) slot_active[hit]--;
            show = 1'b1;
          end
        end
        default: ;
      endcase
      if (show) begin
        r.active_now   = slot_active[hit];
        r.failures_now = slot_fails[hit];
      end
      return r;
    endfunction

    function void note_event(cbt_req_t req);
      owed.push_back(predict_event(req));
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void check_result(cbt_res_t got);
      cbt_res_t want;
      if (owed.size() == 0) begin
        report($sformatf("%0t: unexpected result beat: status %0d active %0d failures %0d",
                         $time, got.status, got.active_now, got.failures_now));
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status || got.active_now !== want.active_now ||
          got.failures_now !== want.failures_now) begin
        report({$sformatf("%0t: result mismatch: want status %0d active %0d failures %0d,",
                          $time, want.status, want.active_now, want.failures_now),
                $sformatf(" got status %0d active %0d failures %0d",
                          got.status, got.active_now, got.failures_now)});
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  breaker_scoreboard sb;
  logic [31:0]       key_pool[KEY_POOL];
  logic [31:0]       wall_secs  = '0;
  int                burst_left = 0;
  int unsigned       cycles     = 0;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result beats cannot be held off, so take each one as it comes
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  // Watchdog
  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic cbt_req_t mk(logic [2:0] op, logic [31:0] key, logic [31:0] now);
    cbt_req_t r;
    r.op          = op_e'(op);
    r.service_key = key;
    r.now_seconds = now;
    return r;
  endfunction

  // Idle gap before a beat, with occasional back-to-back stretches
  function automatic int pick_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 30);
    return $urandom_range(0, 5);
  endfunction

  // Mostly pool keys and a slowly advancing clock; a little noise on top
  function automatic cbt_req_t make_random_event();
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] now;
    int          w;
    w = $urandom_range(0, 99);
    if (w < 18)      op = OP_ATTACH;
    else if (w < 32) op = OP_DETACH;
    else if (w < 62) op = OP_INVOKE;
    else if (w < 84) op = OP_FAILED;
    else if (w < 97) op = OP_FINISH;
    else             op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if (op != OP_ATTACH && $urandom_range(0, 19) == 0) key = $urandom;
    else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    w = $urandom_range(0, 99);
    if (w < 3) begin
      now = $urandom;
    end else begin
      if (w < 5) wall_secs = $urandom;
      else wall_secs = wall_secs + 32'($urandom_range(0, 3));
      now = wall_secs;
    end
    return mk(op, key, now);
  endfunction

  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Present one event beat and hold it until the block takes it
  task automatic send_event(input cbt_req_t req, input int gap, input bit drain);
    if (gap > 0 || drain) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain) wait_drained();
    end
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy);
    sb.note_event(req);
  endtask

  task automatic end_phase();
    start <= 1'b0;
    wait_drained();
  endtask

  // Setup then access cycle on the register port
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_limit(idx, val);
  endtask

  task automatic apply_limits(input logic [15:0] conc, input logic [15:0] fails,
                              input logic [15:0] brk);
    write_reg(REG_MAX_CONC, conc);
    write_reg(REG_MAX_FAIL, fails);
    write_reg(REG_BREAK_SEC, brk);
  endtask

  task automatic run_batch(input cbt_req_t items[$]);
    foreach (items[k]) send_event(items[k], pick_gap(), 1'b0);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++)
      send_event(make_random_event(), pick_gap(), $urandom_range(0, 49) == 0);
  endtask

  initial begin
    cbt_req_t    batch[$];
    logic [31:0] k_lo;
    logic [31:0] k_hi;
    sb   = new();
    k_lo = 32'h0000_0000;
    k_hi = 32'hFFFF_FFFF;
    for (int i = 0; i < KEY_POOL; i++) begin
      if (i == 0)      key_pool[i] = k_lo;
      else if (i == 1) key_pool[i] = k_hi;
      else             key_pool[i] = $urandom;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: missing entries, spare code, refs, underflow, breaker open and close
    batch.push_back(mk(OP_DETACH,   k_lo, 32'd0));
    batch.push_back(mk(OP_FAILED,   k_lo, 32'd0));
    batch.push_back(mk(OP_FINISH,   k_lo, 32'd0));
    batch.push_back(mk(OP_INVOKE,   k_lo, 32'd0));
    batch.push_back(mk(OP_SPARE_HI, k_hi, k_hi));
    batch.push_back(mk(OP_ATTACH,   k_lo, 32'd0));
    batch.push_back(mk(OP_ATTACH,   k_hi, 32'd0));
    batch.push_back(mk(OP_ATTACH,   k_lo, 32'd0));
    batch.push_back(mk(OP_FINISH,   k_lo, 32'd0));
    batch.push_back(mk(OP_INVOKE,   k_lo, 32'd0));
    repeat (4) batch.push_back(mk(OP_FAILED, k_lo, 32'd0));
    batch.push_back(mk(OP_INVOKE,   k_lo, 32'd9));
    batch.push_back(mk(OP_INVOKE,   k_lo, 32'd10));
    batch.push_back(mk(OP_DETACH,   k_lo, 32'd0));
    batch.push_back(mk(OP_DETACH,   k_lo, 32'd0));
    batch.push_back(mk(OP_INVOKE,   k_lo, 32'd0));
    run_batch(batch);
    end_phase();

    // Directed: tightest limits, widest window across the top of the clock
    apply_limits(16'd0, 16'd0, CNT_MAX);
    batch.delete();
    batch.push_back(mk(OP_INVOKE,  k_hi, 32'hFFFF_FFF0));
    batch.push_back(mk(OP_INVOKE,  k_hi, 32'hFFFF_FFF1));
    batch.push_back(mk(OP_FINISH,  k_hi, 32'd0));
    batch.push_back(mk(OP_FAILED,  k_hi, 32'd0));
    batch.push_back(mk(OP_INVOKE,  k_hi, k_hi));
    batch.push_back(mk(OP_SPARE_LO, k_lo, 32'd0));
    run_batch(batch);
    end_phase();

    // Random phases over a spread of limit settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_limits(MAX_CONC_RST, MAX_FAIL_RST, BREAK_SEC_RST);
        1: apply_limits(16'd0, 16'd0, 16'd0);
        2: apply_limits(CNT_MAX, CNT_MAX, CNT_MAX);
        3: apply_limits(16'd2, 16'd1, 16'd4);
        4: apply_limits(16'($urandom_range(0, 5)), 16'($urandom_range(0, 4)),
                        16'($urandom_range(0, 8)));
        default: apply_limits(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      run_random(RAND_PER_PHASE);
      end_phase();
    end

    repeat (SLOTS + 8) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.outstanding() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[service_circuit_breaker_table_top.f]
sv/cbt_pkg.sv
sv/cbt_regs.sv
sv/cbt_ctrl.sv
sv/cbt_dp.sv
sv/service_circuit_breaker_table_top.sv
tb/sv/tb_top.sv
